// ===== hdl/phn_pkg.sv =====
// Shared constants, codes and the job record for the point height normalizer.
package phn_pkg;

  localparam int MAX_CELLS   = 65536;
  localparam int ADDR_W      = $clog2(MAX_CELLS);
  localparam int FRAC_BITS   = 8;
  localparam int DATA_W      = 32;
  localparam int INDEX_W     = 16;
  localparam int SIZE_W      = 24;
  localparam int GRID_W      = 9;
  localparam int DIVISOR_W   = SIZE_W + 1;
  localparam int DW          = 60;
  localparam int PROD_W      = DATA_W + 1 + SIZE_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int PADDR_W     = 5;
  localparam int REG_SEL_W   = 3;

  localparam logic signed [DATA_W-1:0] NODATA = DATA_W'(-9999 * (2 ** FRAC_BITS));

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  localparam logic [REG_SEL_W-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_CELL_SIZE = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_GRID_COLS = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_GRID_ROWS = 3'd4;

  typedef struct packed {
    logic              is_point;
    logic              in_range;
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic [ADDR_W-1:0] addr2;
    logic [SIZE_W-1:0] a;
    logic [SIZE_W-1:0] b;
    logic [SIZE_W-1:0] s;
    logic [DATA_W-1:0] value;
  } phn_job_t;

endpackage

// ===== hdl/phn_in_if.sv =====
// Input channel: load and point commands.
interface phn_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [15:0]        cell_index;
  logic signed [31:0] cell_height;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, command, cell_index, cell_height, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, command, cell_index, cell_height, point_x, point_y, point_z,
                output ready);
endinterface

// ===== hdl/phn_out_if.sv =====
// Output channel: normalized heights with running extremes.
interface phn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] height_above_ground;
  logic               skipped;
  logic signed [31:0] lowest_height;
  logic signed [31:0] highest_height;

  modport source (output valid, height_above_ground, skipped, lowest_height, highest_height,
                  input ready);
  modport sink (input valid, height_above_ground, skipped, lowest_height, highest_height,
                output ready);
endinterface

// ===== hdl/phn_div.sv =====
// Radix-2 restoring floor divider, signed dividend by positive divisor.
module phn_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [phn_pkg::DW-1:0]     dividend,
  input  logic [phn_pkg::DIVISOR_W-1:0]     divisor,
  output logic                              busy,
  output logic                              done,
  output logic signed [phn_pkg::DW-1:0]     quotient,
  output logic [phn_pkg::DIVISOR_W-1:0]     remainder
);
  import phn_pkg::*;

  localparam int CNT_W = $clog2(DW + 1);

  logic                 neg;
  logic [DW-1:0]        quo;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  assign trial = {rem, quo[DW-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DW-1];
      quo <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      rem <= '0;
      dvs <= divisor;
      cnt <= CNT_W'(DW);
    end else if (busy) begin
      quo <= {quo[DW-2:0], ge};
      rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt <= cnt - CNT_W'(1);
    end
  end

  // fold the magnitude result back to floor semantics
  always_comb begin
    if (neg && rem != '0) begin
      quotient  = $signed(~quo);
      remainder = dvs - rem;
    end else begin
      quotient  = neg ? $signed(-quo) : $signed(quo);
      remainder = rem;
    end
  end
endmodule

// ===== hdl/phn_front.sv =====
// Front end: accepts commands, locates the three cells and builds a job.
module phn_front (
  input  logic                          clk,
  input  logic                          rst,
  phn_in_if.sink                        points_in,
  input  logic signed [31:0]            origin_x,
  input  logic signed [31:0]            origin_y,
  input  logic [phn_pkg::SIZE_W-1:0]    cell_size,
  input  logic [phn_pkg::GRID_W-1:0]    grid_cols,
  input  logic [phn_pkg::GRID_W-1:0]    grid_rows,
  input  logic                          full,
  output logic                          push,
  output phn_pkg::phn_job_t             job
);
  import phn_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_DIVX = 3'd1;
  localparam logic [2:0] F_DIVY = 3'd2;
  localparam logic [2:0] F_CALC = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  localparam int AW2 = 2 * GRID_W;

  logic [2:0]               state;
  logic signed [DATA_W-1:0] py_hold;
  logic signed [DW-1:0]     col_q;
  logic signed [DW-1:0]     row_q;
  logic [SIZE_W-1:0]        rx;
  logic [SIZE_W-1:0]        ry;
  logic [SIZE_W-1:0]        cell_edge;
  logic                     accept;
  logic                     div_start;
  logic signed [DW-1:0]     div_dividend;
  logic                     div_busy;
  logic                     div_done;
  logic signed [DW-1:0]     div_q;
  logic [DIVISOR_W-1:0]     div_r;
  logic [DIVISOR_W-1:0]     twice_rx;
  logic [DIVISOR_W-1:0]     twice_ry;
  logic                     east;
  logic                     north;
  logic [SIZE_W-1:0]        a_val;
  logic [SIZE_W-1:0]        b_val;
  logic signed [DW-1:0]     ncol;
  logic signed [DW-1:0]     nrow;
  logic [AW2-1:0]           addr0;
  logic [AW2-1:0]           addr1;
  logic [AW2-1:0]           addr2;
  logic                     cells_ok;

  function automatic logic in_span(logic signed [DW-1:0] c, logic [GRID_W-1:0] n);
    return !c[DW-1] && ($unsigned(c) < DW'(n));
  endfunction

  function automatic logic [AW2-1:0] cell_addr(logic signed [DW-1:0] r, logic signed [DW-1:0] c,
                                                logic [GRID_W-1:0] n);
    return AW2'(r[GRID_W-1:0]) * AW2'(n) + AW2'(c[GRID_W-1:0]);
  endfunction

  assign cell_edge        = (cell_size == '0) ? SIZE_W'(1) : cell_size;
  assign points_in.ready  = (state == F_IDLE);
  assign accept           = points_in.valid && points_in.ready;
  assign push             = (state == F_PUSH) && !full;

  assign div_start    = (accept && points_in.command == CMD_POINT) ||
                        (state == F_DIVX && div_done);
  assign div_dividend = (state == F_IDLE) ? DW'(points_in.point_x) - DW'(origin_x)
                                          : DW'(py_hold) - DW'(origin_y);

  phn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   ({1'b0, cell_edge}),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // pick the neighbor side and the doubled distance from the cell center
  always_comb begin
    twice_rx = {rx, 1'b0};
    twice_ry = {ry, 1'b0};
    east     = twice_rx >= {1'b0, cell_edge};
    north    = twice_ry >= {1'b0, cell_edge};
    a_val    = east  ? SIZE_W'(twice_rx - {1'b0, cell_edge})
                     : SIZE_W'({1'b0, cell_edge} - twice_rx);
    b_val    = north ? SIZE_W'(twice_ry - {1'b0, cell_edge})
                     : SIZE_W'({1'b0, cell_edge} - twice_ry);
    ncol     = east  ? col_q + DW'(1) : col_q - DW'(1);
    nrow     = north ? row_q + DW'(1) : row_q - DW'(1);
    addr0    = cell_addr(row_q, col_q, grid_cols);
    addr1    = cell_addr(row_q, ncol, grid_cols);
    addr2    = cell_addr(nrow, col_q, grid_cols);
    cells_ok = in_span(col_q, grid_cols) && in_span(ncol, grid_cols) &&
               in_span(row_q, grid_rows) && in_span(nrow, grid_rows) &&
               (32'(addr0) < MAX_CELLS) && (32'(addr1) < MAX_CELLS) &&
               (32'(addr2) < MAX_CELLS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) state <= (points_in.command == CMD_POINT) ? F_DIVX : F_PUSH;
        end
        F_DIVX: if (div_done) state <= F_DIVY;
        F_DIVY: if (div_done) state <= F_CALC;
        F_CALC: state <= F_PUSH;
        F_PUSH: if (!full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job.is_point <= points_in.command;
      job.in_range <= 32'(points_in.cell_index) < MAX_CELLS;
      job.addr0    <= ADDR_W'(points_in.cell_index);
      job.value    <= (points_in.command == CMD_POINT) ? points_in.point_z
                                                       : points_in.cell_height;
      py_hold      <= points_in.point_y;
    end
    if (state == F_DIVX && div_done) begin
      col_q <= div_q;
      rx    <= div_r[SIZE_W-1:0];
    end
    if (state == F_DIVY && div_done) begin
      row_q <= div_q;
      ry    <= div_r[SIZE_W-1:0];
    end
    if (state == F_CALC) begin
      job.in_range <= cells_ok;
      job.addr0    <= ADDR_W'(addr0);
      job.addr1    <= ADDR_W'(addr1);
      job.addr2    <= ADDR_W'(addr2);
      job.a        <= a_val;
      job.b        <= b_val;
      job.s        <= cell_edge;
    end
  end

  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    points_in.ready |-> !div_busy)
    else $error("front ready while divider busy");
endmodule

// ===== hdl/phn_queue.sv =====
// Short job queue between front and back.
module phn_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  phn_pkg::phn_job_t push_job,
  output logic              full,
  input  logic              pop,
  output phn_pkg::phn_job_t head,
  output logic              not_empty
);
  import phn_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  phn_job_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue pop while empty");
endmodule

// ===== hdl/phn_back.sv =====
// Back end: grid memory, plane interpolation, result register and extremes.
module phn_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              not_empty,
  input  phn_pkg::phn_job_t head,
  output logic              pop,
  phn_out_if.source         results_out
);
  import phn_pkg::*;

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_RD0  = 4'd1;
  localparam logic [3:0] B_RD1  = 4'd2;
  localparam logic [3:0] B_RD2  = 4'd3;
  localparam logic [3:0] B_RD3  = 4'd4;
  localparam logic [3:0] B_CHK  = 4'd5;
  localparam logic [3:0] B_SUM  = 4'd6;
  localparam logic [3:0] B_DIV  = 4'd7;
  localparam logic [3:0] B_OUT  = 4'd8;

  localparam int GW = DATA_W + 2;

  logic [DATA_W-1:0]        ground_grid [MAX_CELLS];
  logic [3:0]               state;
  phn_job_t                 job;
  logic [ADDR_W-1:0]        rd_addr;
  logic [DATA_W-1:0]        rd_data;
  logic                     wr_en;
  logic signed [DATA_W-1:0] z0;
  logic signed [DATA_W-1:0] z1;
  logic signed [DATA_W-1:0] z2;
  logic signed [DATA_W:0]   dz1;
  logic signed [DATA_W:0]   dz2;
  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;
  logic signed [DATA_W-1:0] h;
  logic                     skip;
  logic signed [DATA_W-1:0] min_height;
  logic signed [DATA_W-1:0] max_height;
  logic signed [DATA_W-1:0] min_next;
  logic signed [DATA_W-1:0] max_next;
  logic                     out_free;
  logic                     nodata_hit;
  logic                     div_start;
  logic signed [DW-1:0]     num;
  logic                     div_busy;
  logic                     div_done;
  logic signed [DW-1:0]     div_q;
  logic [DIVISOR_W-1:0]     div_r;
  logic signed [GW-1:0]     ground;
  logic signed [GW:0]       h_wide;
  logic signed [DATA_W-1:0] h_sat;

  assign pop      = (state == B_IDLE) && not_empty;
  assign wr_en    = pop && !head.is_point && head.in_range;
  assign out_free = !results_out.valid || results_out.ready;

  always_comb begin
    unique case (state)
      B_RD1:   rd_addr = job.addr1;
      B_RD2:   rd_addr = job.addr2;
      default: rd_addr = job.addr0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) ground_grid[head.addr0] <= head.value;
    rd_data <= ground_grid[rd_addr];
  end

  assign dz1        = (DATA_W+1)'(z1) - (DATA_W+1)'(z0);
  assign dz2        = (DATA_W+1)'(z2) - (DATA_W+1)'(z0);
  assign nodata_hit = (z0 == NODATA) || (z1 == NODATA) || (z2 == NODATA);
  assign num        = DW'(p1) + DW'(p2) + DW'($signed({1'b0, job.s}));
  assign div_start  = (state == B_SUM);

  phn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (num),
    .divisor   ({job.s, 1'b0}),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // ground = z0 + floor(num / 2s); saturate the difference to 32 bits
  always_comb begin
    ground = GW'(z0) + GW'(div_q);
    h_wide = (GW+1)'($signed(job.value)) - (GW+1)'(ground);
    if (h_wide > (GW+1)'(32'sh7FFFFFFF))       h_sat = 32'sh7FFFFFFF;
    else if (h_wide < -(GW+1)'(33'sh080000000)) h_sat = 32'sh80000000;
    else                                        h_sat = DATA_W'(h_wide);
    min_next = (!skip && h < min_height) ? h : min_height;
    max_next = (!skip && h > max_height) ? h : max_height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= B_IDLE;
      results_out.valid <= 1'b0;
      min_height        <= 32'sh7FFFFFFF;
      max_height        <= 32'sh80000000;
    end else begin
      if (state == B_OUT && out_free) results_out.valid <= 1'b1;
      else if (results_out.valid && results_out.ready) results_out.valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (pop && head.is_point) state <= head.in_range ? B_RD0 : B_OUT;
        end
        B_RD0: state <= B_RD1;
        B_RD1: state <= B_RD2;
        B_RD2: state <= B_RD3;
        B_RD3: state <= B_CHK;
        B_CHK: state <= nodata_hit ? B_OUT : B_SUM;
        B_SUM: state <= B_DIV;
        B_DIV: if (div_done) state <= B_OUT;
        B_OUT: begin
          if (out_free) begin
            min_height        <= min_next;
            max_height        <= max_next;
            state             <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job  <= head;
      skip <= !head.in_range;
      h    <= '0;
    end
    if (state == B_RD1) z0 <= rd_data;
    if (state == B_RD2) z1 <= rd_data;
    if (state == B_RD3) z2 <= rd_data;
    if (state == B_CHK) begin
      if (nodata_hit) skip <= 1'b1;
      p1 <= $signed({1'b0, job.a}) * dz1;
      p2 <= $signed({1'b0, job.b}) * dz2;
    end
    if (state == B_DIV && div_done) h <= h_sat;
    if (state == B_OUT && out_free) begin
      results_out.height_above_ground <= h;
      results_out.skipped             <= skip;
      results_out.lowest_height       <= min_next;
      results_out.highest_height      <= max_next;
    end
  end

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    results_out.valid && results_out.skipped |-> results_out.height_above_ground == '0)
    else $error("skipped result carries a height");
  a_extremes_order: assert property (@(posedge clk) disable iff (rst)
    results_out.valid && !results_out.skipped |->
      results_out.lowest_height <= results_out.highest_height)
    else $error("running minimum above maximum");
  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == B_DIV)
    else $error("divider busy outside divide state");
endmodule

// ===== hdl/point_height_normalizer_unit.sv =====
// Top level: register port, front end, job queue and back end.
//
//   port         dir   beat / access
//   points_in    in    load cell height or normalize one point
//   results_out  out   one result per point command, none per load
//   apb (p*)     in    origin_x, origin_y, cell_size, grid_cols, grid_rows
//
// A load reaches the grid memory when the back end pops its job from the queue. A point
// passes two 60-step floor divisions for the cell in the front, then three grid memory
// reads and a 60-step division by twice the cell size in the back, each stage with its
// own radix-2 divider. The front takes a new beat once it has pushed the job of a point;
// front and back overlap through a two-entry queue.
// Reset is synchronous; the grid memory is not cleared.
// The output register holds a result while results_out is stalled.
module point_height_normalizer_unit (
  input  logic                         clk,
  input  logic                         rst,
  phn_in_if.sink                       points_in,
  phn_out_if.source                    results_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [phn_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import phn_pkg::*;

  logic signed [31:0]  origin_x;
  logic signed [31:0]  origin_y;
  logic [SIZE_W-1:0]   cell_size;
  logic [GRID_W-1:0]   grid_cols;
  logic [GRID_W-1:0]   grid_rows;
  logic [REG_SEL_W-1:0] reg_sel;
  logic                cfg_write;
  logic                push;
  logic                full;
  logic                pop;
  logic                not_empty;
  phn_job_t            front_job;
  phn_job_t            head;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      cell_size <= SIZE_W'(256);
      grid_cols <= GRID_W'(256);
      grid_rows <= GRID_W'(256);
    end else if (cfg_write && paddr[1:0] == 2'b00) begin
      unique case (reg_sel)
        REG_ORIGIN_X:  origin_x  <= pwdata;
        REG_ORIGIN_Y:  origin_y  <= pwdata;
        REG_CELL_SIZE: cell_size <= pwdata[SIZE_W-1:0];
        REG_GRID_COLS: grid_cols <= pwdata[GRID_W-1:0];
        REG_GRID_ROWS: grid_rows <= pwdata[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ORIGIN_X:  prdata = origin_x;
      REG_ORIGIN_Y:  prdata = origin_y;
      REG_CELL_SIZE: prdata = 32'(cell_size);
      REG_GRID_COLS: prdata = 32'(grid_cols);
      REG_GRID_ROWS: prdata = 32'(grid_rows);
      default:       prdata = '0;
    endcase
  end

  phn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .points_in (points_in),
    .origin_x  (origin_x),
    .origin_y  (origin_y),
    .cell_size (cell_size),
    .grid_cols (grid_cols),
    .grid_rows (grid_rows),
    .full      (full),
    .push      (push),
    .job       (front_job)
  );

  phn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (front_job),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  phn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .not_empty   (not_empty),
    .head        (head),
    .pop         (pop),
    .results_out (results_out)
  );
endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the point height normalizer: directed and random beats.
module testbench;
  import phn_pkg::*;

  typedef struct {
    logic               command;
    logic [15:0]        cell_index;
    logic signed [31:0] cell_height;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } cmd_beat_t;

  typedef struct {
    logic signed [31:0] height_above_ground;
    logic               skipped;
    logic signed [31:0] lowest_height;
    logic signed [31:0] highest_height;
  } height_result_t;

  class height_scoreboard;
    logic [31:0]    ground[int];
    longint         org_x, org_y, csize, cols, rows;
    longint         lowest, highest;
    height_result_t expected_q[$];
    int             errors;

    function new();
      org_x = 0; org_y = 0; csize = 256; cols = 256; rows = 256;
      lowest = 64'sd2147483647; highest = -64'sd2147483648;
      errors = 0;
    endfunction

    function void set_reg(logic [REG_SEL_W-1:0] sel, logic [31:0] v);
      case (sel)
        REG_ORIGIN_X:  org_x = longint'($signed(v));
        REG_ORIGIN_Y:  org_y = longint'($signed(v));
        REG_CELL_SIZE: csize = longint'(v[23:0]);
        REG_GRID_COLS: cols = longint'(v[8:0]);
        REG_GRID_ROWS: rows = longint'(v[8:0]);
        default: ;
      endcase
    endfunction

    function longint edge_len();
      return (csize == 0) ? 1 : csize;
    endfunction

    function longint floor_quot(longint d, longint s, output longint r);
      longint q;
      q = d / s;
      r = d % s;
      if (r < 0) begin
        q -= 1;
        r += s;
      end
      return q;
    endfunction

    // home cell, neighbor cells on the side of the point, doubled distances
    function void place(cmd_beat_t b, output longint col, row, ncol, nrow, da, db);
      longint s, rx, ry;
      s = edge_len();
      col = floor_quot(longint'(b.point_x) - org_x, s, rx);
      row = floor_quot(longint'(b.point_y) - org_y, s, ry);
      if (2 * rx < s) begin
        ncol = col - 1; da = s - 2 * rx;
      end else begin
        ncol = col + 1; da = 2 * rx - s;
      end
      if (2 * ry < s) begin
        nrow = row - 1; db = s - 2 * ry;
      end else begin
        nrow = row + 1; db = 2 * ry - s;
      end
    endfunction

    function bit cell_addr(longint col, longint row, output int addr);
      longint a;
      addr = 0;
      if (col < 0 || row < 0 || col >= cols || row >= rows) return 0;
      a = row * cols + col;
      if (a >= MAX_CELLS) return 0;
      addr = int'(a);
      return 1;
    endfunction

    // in-grid cells of a point that were never loaded
    function void unloaded_cells(cmd_beat_t b, output int miss[$]);
      longint col, row, ncol, nrow, da, db;
      int     ad;
      miss = {};
      place(b, col, row, ncol, nrow, da, db);
      if (cell_addr(col, row, ad) && !ground.exists(ad)) miss = {miss, ad};
      if (cell_addr(ncol, row, ad) && !ground.exists(ad)) miss = {miss, ad};
      if (cell_addr(col, nrow, ad) && !ground.exists(ad)) miss = {miss, ad};
    endfunction

    function void note_input(cmd_beat_t b);
      longint         col, row, ncol, nrow, da, db, s, z0, z1, z2, num, rem, h;
      int             a0, a1, a2;
      bit             ok;
      height_result_t r;
      if (b.command == CMD_LOAD) begin
        ground[int'(b.cell_index)] = b.cell_height;
        return;
      end
      s = edge_len();
      place(b, col, row, ncol, nrow, da, db);
      ok = cell_addr(col, row, a0) && cell_addr(ncol, row, a1) && cell_addr(col, nrow, a2);
      if (ok)
        ok = ground[a0] != NODATA && ground[a1] != NODATA && ground[a2] != NODATA;
      if (!ok) begin
        r.height_above_ground = 0;
        r.skipped = 1'b1;
      end else begin
        z0 = longint'($signed(ground[a0]));
        z1 = longint'($signed(ground[a1]));
        z2 = longint'($signed(ground[a2]));
        num = da * (z1 - z0) + db * (z2 - z0) + s;
        h = longint'(b.point_z) - (z0 + floor_quot(num, 2 * s, rem));
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (h < -64'sd2147483648) h = -64'sd2147483648;
        if (h < lowest) lowest = h;
        if (h > highest) highest = h;
        r.height_above_ground = h[31:0];
        r.skipped = 1'b0;
      end
      r.lowest_height = lowest[31:0];
      r.highest_height = highest[31:0];
      expected_q = {expected_q, r};
    endfunction

    function void check_result(height_result_t got);
      height_result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.skipped !== want.skipped) begin
        $error("skipped expected %0d got %0d", want.skipped, got.skipped);
        errors++;
      end
      if (got.height_above_ground !== want.height_above_ground) begin
        $error("height_above_ground expected %0d got %0d",
               want.height_above_ground, got.height_above_ground);
        errors++;
      end
      if (got.lowest_height !== want.lowest_height) begin
        $error("lowest_height expected %0d got %0d", want.lowest_height, got.lowest_height);
        errors++;
      end
      if (got.highest_height !== want.highest_height) begin
        $error("highest_height expected %0d got %0d", want.highest_height, got.highest_height);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  bit          quiet;
  int          sent;

  phn_in_if  pin();
  phn_out_if pout();

  height_scoreboard sb = new();

  point_height_normalizer_unit dut (
    .clk(clk), .rst(rst), .points_in(pin), .results_out(pout),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk) pout.ready = !rst && (quiet || $urandom_range(99) >= 22);

  always @(posedge clk) begin
    if (!rst && pout.valid === 1'b1 && pout.ready)
      sb.check_result('{pout.height_above_ground, pout.skipped,
                        pout.lowest_height, pout.highest_height});
  end

  task automatic send_beat(cmd_beat_t b);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 22) begin
      pin.valid = 1'b0;
      @(negedge clk);
    end
    pin.valid = 1'b1;
    pin.command = b.command;
    pin.cell_index = b.cell_index;
    pin.cell_height = b.cell_height;
    pin.point_x = b.point_x;
    pin.point_y = b.point_y;
    pin.point_z = b.point_z;
    do @(posedge clk); while (pin.ready !== 1'b1);
    sb.note_input(b);
    sent++;
  endtask

  function automatic logic signed [31:0] rand_height();
    case ($urandom_range(9))
      0: return NODATA;
      1: return $urandom;
      default: return $signed($urandom_range(1 << 23)) - (1 << 22);
    endcase
  endfunction

  task automatic load_cell(int idx, logic signed [31:0] h);
    cmd_beat_t b;
    b = '{CMD_LOAD, idx[15:0], h, $urandom, $urandom, $urandom};
    send_beat(b);
  endtask

  // load any unwritten in-grid cell the point touches, then send it
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
    cmd_beat_t b;
    int        miss[$];
    b = '{CMD_POINT, 16'($urandom), $urandom, x, y, z};
    sb.unloaded_cells(b, miss);
    foreach (miss[k]) load_cell(miss[k], rand_height());
    send_beat(b);
  endtask

  task automatic reg_write(logic [REG_SEL_W-1:0] sel, logic [31:0] v);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = PADDR_W'({sel, 2'b00}); pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    sb.set_reg(sel, v);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic wait_drained();
    // drop the last beat so it is not taken again
    @(negedge clk);
    pin.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    // loads leave no result; let the block settle
    repeat (300) @(posedge clk);
  endtask

  task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] cs,
                          logic [31:0] nc, logic [31:0] nr);
    wait_drained();
    reg_write(REG_ORIGIN_X, ox);
    reg_write(REG_ORIGIN_Y, oy);
    reg_write(REG_CELL_SIZE, cs);
    reg_write(REG_GRID_COLS, nc);
    reg_write(REG_GRID_ROWS, nr);
  endtask

  task automatic random_beat();
    longint s, col, row, rx, ry, px, py;
    int     idx;
    s = sb.edge_len();
    if ($urandom_range(99) < 30) begin
      if ($urandom_range(99) < 85) idx = $urandom_range(int'(sb.cols * sb.rows) - 1);
      else idx = $urandom_range(65535);
      load_cell(idx, rand_height());
    end else if ($urandom_range(99) < 5) begin
      send_point($urandom, $urandom, $urandom);
    end else begin
      col = longint'($urandom_range(int'(sb.cols) + 1)) - 1;
      row = longint'($urandom_range(int'(sb.rows) + 1)) - 1;
      case ($urandom_range(3))
        0: begin rx = 0; ry = s - 1; end
        1: begin rx = s / 2; ry = s / 2; end
        default: begin
          rx = $urandom_range(int'(s) - 1);
          ry = $urandom_range(int'(s) - 1);
        end
      endcase
      px = sb.org_x + col * s + rx;
      py = sb.org_y + row * s + ry;
      send_point(px[31:0], py[31:0],
                 ($urandom_range(9) == 0) ? $signed($urandom)
                                          : $signed($urandom_range(1 << 24)) - (1 << 23));
    end
  endtask

  initial begin
    int base;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    pin.valid = 1'b0; pin.command = CMD_LOAD; pin.cell_index = '0;
    pin.cell_height = '0; pin.point_x = '0; pin.point_y = '0; pin.point_z = '0;
    pout.ready = 1'b0;
    quiet = 1'b0;
    sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset grid, 256x256 cells of one unit
    load_cell(0, 100 * 256);
    load_cell(1, 200 * 256);
    load_cell(256, -50 * 256);
    load_cell(257, 0);
    send_point(128, 128, 1000);              // exactly on both center lines
    send_point(0, 0, 0);
    send_point(255, 255, 5);
    send_point(-1, 10, 0);                   // home column below the grid
    send_point(255 * 256 + 200, 0, 0);       // neighbor past the last column
    send_point(10, 255 * 256 + 200, 0);      // neighbor past the last row
    load_cell(512, NODATA);
    send_point(10, 2 * 256 + 10, 0);         // nodata home cell
    load_cell(2570, 32'h8000_0000);
    load_cell(2569, 32'h8000_0000);
    load_cell(2314, 32'h8000_0000);
    send_point(2570, 2570, 32'h7FFF_FFFF);   // saturate upward
    load_cell(5140, 32'h7FFF_FFFF);
    load_cell(5139, 32'h7FFF_FFFF);
    load_cell(4884, 32'h7FFF_FFFF);
    send_point(5130, 5130, 32'h8000_0000);   // saturate downward
    load_cell(65535, 1234);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);

    base = sent;
    for (int p = 1; p <= 6; p++) begin
      case (p)
        1: set_grid(-256000, 512000, 256, 16, 16);
        2: set_grid(0, 0, 1, 256, 256);
        3: set_grid(32'h8000_0000, 32'h8000_0005, 24'hFF_FFFF, 2, 2);
        4: set_grid(32'h7FFF_0000, -1000, 0, 7, 5);
        5: set_grid(-77777, 33333, 300, 256, 3);
        default: set_grid($signed($urandom_range(1 << 20)) - (1 << 19),
                          $signed($urandom_range(1 << 20)) - (1 << 19),
                          $urandom_range(1, 4096), $urandom_range(1, 256),
                          $urandom_range(1, 256));
      endcase
      quiet = (p == 3);
      while (sent < base + p * 168) random_beat();
    end
    quiet = 1'b0;
    @(negedge clk);
    pin.valid = 1'b0;
    wait_drained();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
